@@ rtl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file of the undistortion map block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked in the same cycle.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/fum_pkg.sv @@
// Package: constants, types and arithmetic helpers of the undistortion map.
package fum_pkg;

    localparam int MAX_WIDTH     = 2048;
    localparam int MAX_HEIGHT    = 2048;
    localparam int SUBPIXEL_BITS = 5;
    localparam int CORDIC_STEPS  = 28;
    localparam int IU_W          = 16 + SUBPIXEL_BITS;

    // saturated Q.30 intermediates
    typedef logic signed [34:0] q30_t;
    // unsigned product of two magnitudes
    typedef logic [67:0] prod_t;
    typedef logic signed [68:0] wide_t;

    localparam q30_t ONE30 = 35'sd1073741824;
    localparam q30_t SAT34 = 35'sd17179869183;

    localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
        32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
        32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
        32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
        32'd128, 32'd64, 32'd32, 32'd16, 32'd8
    };

    typedef enum logic [2:0] {
        REG_FOCAL      = 3'd0,
        REG_CENTER     = 3'd1,
        REG_INV_FOCAL  = 3'd2,
        REG_NEW_CENTER = 3'd3,
        REG_COEFF_LOW  = 3'd4,
        REG_COEFF_HIGH = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [31:0]        fx;
        logic [31:0]        fy;
        logic [31:0]        cx;
        logic [31:0]        cy;
        logic [31:0]        ifx;
        logic [31:0]        ify;
        logic [31:0]        ncx;
        logic [31:0]        ncy;
        logic signed [31:0] k1;
        logic signed [31:0] k2;
        logic signed [31:0] k3;
        logic signed [31:0] k4;
    } cfg_t;

    // point data that travels alongside the radius path
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [31:0]        r;
        logic               rzero;
    } side_t;

    // round(p / 2^s) half up on the magnitude, then apply the sign
    function automatic wide_t round_shift(prod_t p, logic neg, int s);
        logic [67:0] t;
        t = (p + (68'd1 << (s - 1))) >> s;
        return neg ? -$signed({1'b0, t}) : $signed({1'b0, t});
    endfunction

    function automatic q30_t sat34(wide_t v);
        if (v > wide_t'(SAT34))
            return SAT34;
        else if (v < -wide_t'(SAT34))
            return -SAT34;
        return v[34:0];
    endfunction

    function automatic logic [34:0] mag35(q30_t v);
        return v[34] ? 35'(-v) : 35'(v);
    endfunction

endpackage

@@ rtl/fisheye_undistort_map.sv @@
// Top level: configuration registers, radius/angle/polynomial/divider chain and projection.
// Throughput: one pixel per cycle; each stage is at most one multiply or two iteration steps.
// The whole pipeline advances when the output register is empty or taken; a stall holds it.
// Reset (rst_n, asynchronous, active low) clears all valid bits and the configuration to 0.
`include "assert_macros.svh"

module fisheye_undistort_map (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // out_col[10:0], out_row[21:11], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // src_x_int[15:0], src_y_int[31:16], frac_index[41:32], pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import fum_pkg::*;

    localparam int SH = 16 - SUBPIXEL_BITS;

    logic               en;
    cfg_t               cfg_reg;
    logic               rad_vld, at_vld, poly_vld, scale_vld;
    side_t              rad_side, at_side, poly_side, scale_side;
    logic [31:0]        at_theta;
    q30_t               poly_td, scale;
    logic [3:0]         bk_reg;
    prod_t              pxb_reg, pyb_reg, pu_reg, pv_reg;
    logic               ngx_reg, ngy_reg, ngu_reg, ngv_reg;
    q30_t               xd_reg, yd_reg;
    logic signed [IU_W-1:0] iu_reg, iv_reg;
    logic [31:0]        ax, ay;
    logic [34:0]        asc, axd, ayd;
    logic [2*SUBPIXEL_BITS-1:0] frac_pair;

    // saturated subpixel coordinate from the Q.16 position
    function automatic logic signed [IU_W-1:0] to_sub(wide_t p, logic [31:0] c);
        logic signed [70:0] u, iu;
        u  = 71'(p) + $signed({39'b0, c});
        iu = (u + (71'sd1 <<< (SH - 1))) >>> SH;
        if (iu > 71'((71'sd1 <<< (IU_W - 1)) - 1))
            return {1'b0, {(IU_W-1){1'b1}}};
        else if (iu < -(71'sd1 <<< (IU_W - 1)))
            return {1'b1, {(IU_W-1){1'b0}}};
        return iu[IU_W-1:0];
    endfunction

    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_valid)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_FOCAL:
                begin
                    cfg_reg.fx <= cfg_data[31:0];
                    cfg_reg.fy <= cfg_data[63:32];
                end
                REG_CENTER:
                begin
                    cfg_reg.cx <= cfg_data[31:0];
                    cfg_reg.cy <= cfg_data[63:32];
                end
                REG_INV_FOCAL:
                begin
                    cfg_reg.ifx <= cfg_data[31:0];
                    cfg_reg.ify <= cfg_data[63:32];
                end
                REG_NEW_CENTER:
                begin
                    cfg_reg.ncx <= cfg_data[31:0];
                    cfg_reg.ncy <= cfg_data[63:32];
                end
                REG_COEFF_LOW:
                begin
                    cfg_reg.k1 <= cfg_data[31:0];
                    cfg_reg.k2 <= cfg_data[63:32];
                end
                REG_COEFF_HIGH:
                begin
                    cfg_reg.k3 <= cfg_data[31:0];
                    cfg_reg.k4 <= cfg_data[63:32];
                end
                default:
                begin
                end
            endcase
        end
    end

    fum_radius u_radius (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s_tvalid),
        .in_col   (s_tdata[10:0]),
        .in_row   (s_tdata[21:11]),
        .cfg      (cfg_reg),
        .out_vld  (rad_vld),
        .out_side (rad_side)
    );

    fum_atan u_atan (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_vld    (rad_vld),
        .in_side   (rad_side),
        .out_vld   (at_vld),
        .out_side  (at_side),
        .out_theta (at_theta)
    );

    fum_poly u_poly (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .cfg      (cfg_reg),
        .in_vld   (at_vld),
        .in_side  (at_side),
        .in_theta (at_theta),
        .out_vld  (poly_vld),
        .out_side (poly_side),
        .out_td   (poly_td)
    );

    fum_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_vld    (poly_vld),
        .in_side   (poly_side),
        .in_td     (poly_td),
        .out_vld   (scale_vld),
        .out_side  (scale_side),
        .out_scale (scale)
    );

    // operand magnitudes for the projection multiplies
    always_comb
    begin
        ax  = scale_side.x[31] ? 32'(-scale_side.x) : 32'(scale_side.x);
        ay  = scale_side.y[31] ? 32'(-scale_side.y) : 32'(scale_side.y);
        asc = mag35(scale);
        axd = mag35(xd_reg);
        ayd = mag35(yd_reg);
    end

    // projection: x*scale, focal multiply, centre add and subpixel rounding
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pxb_reg <= prod_t'(ax) * prod_t'(asc);
            pyb_reg <= prod_t'(ay) * prod_t'(asc);
            ngx_reg <= scale_side.x[31] ^ scale[34];
            ngy_reg <= scale_side.y[31] ^ scale[34];
            xd_reg  <= sat34(round_shift(pxb_reg, ngx_reg, 30));
            yd_reg  <= sat34(round_shift(pyb_reg, ngy_reg, 30));
            pu_reg  <= prod_t'(cfg_reg.fx) * prod_t'(axd);
            pv_reg  <= prod_t'(cfg_reg.fy) * prod_t'(ayd);
            ngu_reg <= xd_reg[34];
            ngv_reg <= yd_reg[34];
            iu_reg  <= to_sub(round_shift(pu_reg, ngu_reg, 28), cfg_reg.cx);
            iv_reg  <= to_sub(round_shift(pv_reg, ngv_reg, 28), cfg_reg.cy);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bk_reg <= '0;
        else if (en)
            bk_reg <= {bk_reg[2:0], scale_vld};
    end

    // result packing
    assign frac_pair = {iv_reg[SUBPIXEL_BITS-1:0], iu_reg[SUBPIXEL_BITS-1:0]};
    assign m_tvalid  = bk_reg[3];
    assign m_tdata   = {6'b0, 10'(frac_pair),
                        iv_reg[IU_W-1:SUBPIXEL_BITS], iu_reg[IU_W-1:SUBPIXEL_BITS]};

    `ASSERT_IMPL(a_stall_only_on_held_output, !s_tready, m_tvalid && !m_tready, "input stalled without a held result")
    `ASSERT_IMPL(a_unit_scale_at_centre, scale_vld && scale_side.rzero, scale == ONE30, "scale not one at zero radius")
    `ASSERT_ALWAYS(a_scale_in_range, !scale_vld || (scale <= SAT34 && scale >= -SAT34), "scale outside saturation range")

endmodule

@@ rtl/fum_radius.sv @@
// Normalisation of the pixel position and pipelined integer square root of the radius.
module fum_radius (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_vld,
    input  logic [10:0]    in_col,
    input  logic [10:0]    in_row,
    input  fum_pkg::cfg_t  cfg,
    output logic           out_vld,
    output fum_pkg::side_t out_side
);
    import fum_pkg::*;

    localparam int ISQ_PER = 2;
    localparam int ISQ_ST  = 32 / ISQ_PER;

    logic [4:0]              vf_reg;
    logic [ISQ_ST-1:0]       vq_reg;
    logic [10:0]             col_reg, row_reg;
    prod_t                   prx_reg, pry_reg;
    logic                    ngx_reg, ngy_reg;
    logic signed [31:0]      x2_reg, y2_reg, x3_reg, y3_reg, x4_reg, y4_reg;
    logic [63:0]             sqx_reg, sqy_reg, sum_reg;
    logic [63:0]             v_reg [ISQ_ST];
    logic [63:0]             res_reg [ISQ_ST];
    logic signed [31:0]      xs_reg [ISQ_ST];
    logic signed [31:0]      ys_reg [ISQ_ST];
    logic [63:0]             v_next [ISQ_ST];
    logic [63:0]             res_next [ISQ_ST];
    logic [10:0]             col_c, row_c;
    logic signed [33:0]      dx, dy;
    logic [33:0]             adx, ady;
    logic [31:0]             ax, ay;

    function automatic logic signed [31:0] sat32(wide_t v);
        if (v > 69'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -69'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // frame clamp
    always_comb
    begin
        col_c = ({3'b0, in_col} > 14'(MAX_WIDTH - 1)) ? 11'(MAX_WIDTH - 1) : in_col;
        row_c = ({3'b0, in_row} > 14'(MAX_HEIGHT - 1)) ? 11'(MAX_HEIGHT - 1) : in_row;
    end

    // offset from the new centre and magnitudes
    always_comb
    begin
        dx  = $signed({7'b0, col_reg, 16'b0}) - $signed({2'b0, cfg.ncx});
        dy  = $signed({7'b0, row_reg, 16'b0}) - $signed({2'b0, cfg.ncy});
        adx = dx[33] ? 34'(-dx) : 34'(dx);
        ady = dy[33] ? 34'(-dy) : 34'(dy);
        ax  = x2_reg[31] ? 32'(-x2_reg) : 32'(x2_reg);
        ay  = y2_reg[31] ? 32'(-y2_reg) : 32'(y2_reg);
    end

    // square root, two result bits per stage
    always_comb
    begin
        logic [63:0] vt, rt, bt;
        for (int s = 0; s < ISQ_ST; s++)
        begin
            vt = (s == 0) ? sum_reg : v_reg[(s == 0) ? 0 : s - 1];
            rt = (s == 0) ? 64'd0 : res_reg[(s == 0) ? 0 : s - 1];
            for (int j = 0; j < ISQ_PER; j++)
            begin
                bt = 64'd1 << (62 - 2 * (s * ISQ_PER + j));
                if (vt >= rt + bt)
                begin
                    vt = vt - (rt + bt);
                    rt = (rt >> 1) + bt;
                end
                else
                begin
                    rt = rt >> 1;
                end
            end
            v_next[s]   = vt;
            res_next[s] = rt;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            col_reg <= col_c;
            row_reg <= row_c;
            prx_reg <= prod_t'(adx) * prod_t'(cfg.ifx);
            pry_reg <= prod_t'(ady) * prod_t'(cfg.ify);
            ngx_reg <= dx[33];
            ngy_reg <= dy[33];
            x2_reg  <= sat32(round_shift(prx_reg, ngx_reg, 20));
            y2_reg  <= sat32(round_shift(pry_reg, ngy_reg, 20));
            sqx_reg <= 64'(ax) * 64'(ax);
            sqy_reg <= 64'(ay) * 64'(ay);
            x3_reg  <= x2_reg;
            y3_reg  <= y2_reg;
            sum_reg <= sqx_reg + sqy_reg;
            x4_reg  <= x3_reg;
            y4_reg  <= y3_reg;
            for (int s = 0; s < ISQ_ST; s++)
            begin
                v_reg[s]   <= v_next[s];
                res_reg[s] <= res_next[s];
                xs_reg[s]  <= (s == 0) ? x4_reg : xs_reg[(s == 0) ? 0 : s - 1];
                ys_reg[s]  <= (s == 0) ? y4_reg : ys_reg[(s == 0) ? 0 : s - 1];
            end
        end
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vf_reg <= '0;
            vq_reg <= '0;
        end
        else if (en)
        begin
            vf_reg <= {vf_reg[3:0], in_vld};
            vq_reg <= {vq_reg[ISQ_ST-2:0], vf_reg[4]};
        end
    end

    assign out_vld        = vq_reg[ISQ_ST-1];
    assign out_side.x     = xs_reg[ISQ_ST-1];
    assign out_side.y     = ys_reg[ISQ_ST-1];
    assign out_side.r     = res_reg[ISQ_ST-1][31:0];
    assign out_side.rzero = (res_reg[ISQ_ST-1][31:0] == 32'd0);

endmodule

@@ rtl/fum_atan.sv @@
// Pipelined CORDIC vectoring that gives theta = atan(r) in Q2.30.
module fum_atan (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_vld,
    input  fum_pkg::side_t in_side,
    output logic           out_vld,
    output fum_pkg::side_t out_side,
    output logic [31:0]    out_theta
);
    import fum_pkg::*;

    localparam int AT_PER = 2;
    localparam int AT_ST  = CORDIC_STEPS / AT_PER;

    logic [AT_ST-1:0]    vld_reg;
    logic signed [39:0]  cx_reg [AT_ST];
    logic signed [39:0]  cy_reg [AT_ST];
    logic signed [33:0]  z_reg [AT_ST];
    side_t               sd_reg [AT_ST];
    logic signed [39:0]  cx_next [AT_ST];
    logic signed [39:0]  cy_next [AT_ST];
    logic signed [33:0]  z_next [AT_ST];

    // two micro-rotations per stage
    always_comb
    begin
        logic signed [39:0] xt, yt, ddx, ddy;
        logic signed [33:0] zt, at;
        for (int s = 0; s < AT_ST; s++)
        begin
            xt = (s == 0) ? 40'sd268435456 : cx_reg[(s == 0) ? 0 : s - 1];
            yt = (s == 0) ? $signed({8'b0, in_side.r}) : cy_reg[(s == 0) ? 0 : s - 1];
            zt = (s == 0) ? 34'sd0 : z_reg[(s == 0) ? 0 : s - 1];
            for (int j = 0; j < AT_PER; j++)
            begin
                ddx = yt >>> (s * AT_PER + j);
                ddy = xt >>> (s * AT_PER + j);
                at  = $signed({2'b0, ATAN_TAB[s * AT_PER + j]});
                if (!yt[39])
                begin
                    xt = xt + ddx;
                    yt = yt - ddy;
                    zt = zt + at;
                end
                else
                begin
                    xt = xt - ddx;
                    yt = yt + ddy;
                    zt = zt - at;
                end
            end
            cx_next[s] = xt;
            cy_next[s] = yt;
            z_next[s]  = zt;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < AT_ST; s++)
            begin
                cx_reg[s] <= cx_next[s];
                cy_reg[s] <= cy_next[s];
                z_reg[s]  <= z_next[s];
                sd_reg[s] <= (s == 0) ? in_side : sd_reg[(s == 0) ? 0 : s - 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[AT_ST-2:0], in_vld};
    end

    // negative angle clamps at zero
    assign out_vld   = vld_reg[AT_ST-1];
    assign out_side  = sd_reg[AT_ST-1];
    assign out_theta = z_reg[AT_ST-1][33] ? 32'd0 : z_reg[AT_ST-1][31:0];

endmodule

@@ rtl/fum_poly.sv @@
// Distortion polynomial theta_d in Horner form, one multiply and one round stage per term.
module fum_poly (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  fum_pkg::cfg_t  cfg,
    input  logic           in_vld,
    input  fum_pkg::side_t in_side,
    input  logic [31:0]    in_theta,
    output logic           out_vld,
    output fum_pkg::side_t out_side,
    output fum_pkg::q30_t  out_td
);
    import fum_pkg::*;

    localparam int NSTEP = 5;

    logic               v0_reg;
    logic [63:0]        sq_reg;
    logic [31:0]        th0_reg;
    side_t              sd0_reg;
    logic [NSTEP:0]     vb_reg;
    q30_t               acc_reg [NSTEP+1];
    logic [31:0]        t2b_reg [NSTEP+1];
    logic [31:0]        thb_reg [NSTEP+1];
    side_t              sdb_reg [NSTEP+1];
    logic [NSTEP-1:0]   va_reg;
    prod_t              pr_reg [NSTEP];
    logic               ng_reg [NSTEP];
    logic [31:0]        t2a_reg [NSTEP];
    logic [31:0]        tha_reg [NSTEP];
    side_t              sda_reg [NSTEP];
    wide_t              t2_full;

    // constant added after each Horner multiply
    function automatic q30_t horner_term(int i, cfg_t c);
        case (i)
            0:       return q30_t'(c.k3);
            1:       return q30_t'(c.k2);
            2:       return q30_t'(c.k1);
            3:       return ONE30;
            default: return '0;
        endcase
    endfunction

    assign t2_full = round_shift(prod_t'(sq_reg), 1'b0, 30);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // theta squared
            sq_reg     <= 64'(in_theta) * 64'(in_theta);
            th0_reg    <= in_theta;
            sd0_reg    <= in_side;
            t2b_reg[0] <= t2_full[31:0];
            thb_reg[0] <= th0_reg;
            sdb_reg[0] <= sd0_reg;
            acc_reg[0] <= q30_t'(cfg.k4);
            for (int i = 0; i < NSTEP; i++)
            begin
                // multiply stage
                pr_reg[i]  <= prod_t'(mag35(acc_reg[i]))
                            * prod_t'((i == NSTEP - 1) ? thb_reg[i] : t2b_reg[i]);
                ng_reg[i]  <= acc_reg[i][34];
                t2a_reg[i] <= t2b_reg[i];
                tha_reg[i] <= thb_reg[i];
                sda_reg[i] <= sdb_reg[i];
                // round, add and saturate stage
                acc_reg[i+1] <= sat34(wide_t'(horner_term(i, cfg))
                                      + round_shift(pr_reg[i], ng_reg[i], 30));
                t2b_reg[i+1] <= t2a_reg[i];
                thb_reg[i+1] <= tha_reg[i];
                sdb_reg[i+1] <= sda_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            vb_reg <= '0;
            va_reg <= '0;
        end
        else if (en)
        begin
            v0_reg <= in_vld;
            vb_reg <= {va_reg, v0_reg};
            va_reg <= vb_reg[NSTEP-1:0];
        end
    end

    assign out_vld  = vb_reg[NSTEP];
    assign out_side = sdb_reg[NSTEP];
    assign out_td   = acc_reg[NSTEP];

endmodule

@@ rtl/fum_scale.sv @@
// Pipelined restoring divider for scale = theta_d / r, saturated, with the unit case at r = 0.
module fum_scale (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_vld,
    input  fum_pkg::side_t in_side,
    input  fum_pkg::q30_t  in_td,
    output logic           out_vld,
    output fum_pkg::side_t out_side,
    output fum_pkg::q30_t  out_scale
);
    import fum_pkg::*;

    localparam int DV_PER = 2;
    localparam int QB     = 34;
    localparam int DV_ST  = QB / DV_PER;

    logic               v0_reg;
    logic [65:0]        rem0_reg;
    logic               ovf0_reg, neg0_reg;
    side_t              sd0_reg;
    logic [DV_ST-1:0]   vld_reg;
    logic [65:0]        rem_reg [DV_ST];
    logic [QB-1:0]      q_reg [DV_ST];
    logic               ovf_reg [DV_ST];
    logic               neg_reg [DV_ST];
    side_t              sd_reg [DV_ST];
    logic [65:0]        rem_next [DV_ST];
    logic [QB-1:0]      q_next [DV_ST];
    logic [34:0]        mag;
    logic [65:0]        num;
    logic [34:0]        qsat;

    // numerator with rounding, used by the divider and its quotient overflow test
    always_comb
    begin
        mag = mag35(in_td);
        num = ({32'b0, mag[33:0]} << 28) + {35'b0, in_side.r[31:1]};
    end

    // two quotient bits per stage
    always_comb
    begin
        logic [65:0] rt, sub;
        logic [QB-1:0] qt;
        logic [31:0] den;
        for (int s = 0; s < DV_ST; s++)
        begin
            rt  = (s == 0) ? rem0_reg : rem_reg[(s == 0) ? 0 : s - 1];
            qt  = (s == 0) ? '0 : q_reg[(s == 0) ? 0 : s - 1];
            den = (s == 0) ? sd0_reg.r : sd_reg[(s == 0) ? 0 : s - 1].r;
            for (int j = 0; j < DV_PER; j++)
            begin
                sub = {34'b0, den} << (QB - 1 - (s * DV_PER + j));
                if (rt >= sub)
                begin
                    rt = rt - sub;
                    qt = {qt[QB-2:0], 1'b1};
                end
                else
                begin
                    qt = {qt[QB-2:0], 1'b0};
                end
            end
            rem_next[s] = rt;
            q_next[s]   = qt;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem0_reg <= num;
            ovf0_reg <= (num >= ({34'b0, in_side.r} << QB));
            neg0_reg <= in_td[34];
            sd0_reg  <= in_side;
            for (int s = 0; s < DV_ST; s++)
            begin
                rem_reg[s] <= rem_next[s];
                q_reg[s]   <= q_next[s];
                ovf_reg[s] <= (s == 0) ? ovf0_reg : ovf_reg[(s == 0) ? 0 : s - 1];
                neg_reg[s] <= (s == 0) ? neg0_reg : neg_reg[(s == 0) ? 0 : s - 1];
                sd_reg[s]  <= (s == 0) ? sd0_reg : sd_reg[(s == 0) ? 0 : s - 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg  <= 1'b0;
            vld_reg <= '0;
        end
        else if (en)
        begin
            v0_reg  <= in_vld;
            vld_reg <= {vld_reg[DV_ST-2:0], v0_reg};
        end
    end

    // saturation, sign and the zero-radius case
    always_comb
    begin
        qsat = ovf_reg[DV_ST-1] ? 35'(SAT34) : {1'b0, q_reg[DV_ST-1]};
        if (sd_reg[DV_ST-1].rzero)
            out_scale = ONE30;
        else if (neg_reg[DV_ST-1])
            out_scale = -$signed(qsat);
        else
            out_scale = $signed(qsat);
    end

    assign out_vld  = vld_reg[DV_ST-1];
    assign out_side = sd_reg[DV_ST-1];

endmodule
